>>> rtl/core/lpahp_pkg.sv
// package with types and constants of the length-prefixed auth header parser
`timescale 1ns / 1ps

package lpahp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgServicePort  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAuthOpcode   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinNameLen   = 2'd2;

  localparam logic [15:0] ServicePortRst = 16'd3724;
  localparam logic [31:0] AuthOpcodeRst  = 32'd493;
  localparam logic [5:0]  MinNameLenRst  = 6'd3;

  localparam logic [15:0] NameMaxLength  = 16'd63;
  localparam logic [15:0] PosMax         = 16'hFFFF;
  localparam logic [15:0] MinMatchLen    = 16'd6;
  localparam logic [15:0] OpcodeLen      = 16'd10;
  localparam logic [15:0] ScanStart      = 16'd10;
  localparam logic [7:0]  PrintLow       = 8'd32;
  localparam logic [7:0]  PrintHigh      = 8'd126;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 96;

  typedef struct packed {
    logic [5:0]  name_length;
    logic [15:0] name_offset;
    logic        name_found;
    logic [31:0] client_build;
    logic        is_auth;
    logic [31:0] opcode;
    logic        opcode_valid;
    logic        length_match;
  } report_t;

  localparam int unsigned ReportW = $bits(report_t);

endpackage

>>> rtl/core/length_prefixed_auth_header_parser_top.sv
// top level of the length-prefixed auth header parser
//
// channel    | dir | handshake                  | words
// s_axis     | in  | tvalid/tready, tdata/tuser | one payload byte, tlast on final byte
// m_axis     | out | tvalid/tready, tdata       | one report per packet
// cfg        | in  | cfg_we_i, no wait          | register writes
//
// one byte per cycle while the report is not stalled; the last byte passes the input register, then the report register
// stages: input register, then byte state update and the report register
// reset clears the counters, packet state and valid flags and sets the config registers to their defaults
// a stalled report holds both stages; a byte still enters an empty input register while the report waits
`timescale 1ns / 1ps

module length_prefixed_auth_header_parser_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // data_byte [7:0], dest_port [23:8]
  input  logic [lpahp_pkg::InDataW-1:0]     s_axis_tdata_i,
  // is_tcp [0]
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // length_match [0], opcode_valid [1], opcode [33:2], is_auth [34],
  // client_build [66:35], name_found [67], name_offset [83:68], name_length [89:84]
  output logic [lpahp_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input  logic                              cfg_we_i,
  input  logic [lpahp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lpahp_pkg::CfgDataW-1:0]    cfg_data_i
);

  // configuration
  logic [15:0] service_port_q;
  logic [31:0] auth_opcode_q;
  logic [5:0]  min_name_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      service_port_q <= lpahp_pkg::ServicePortRst;
      auth_opcode_q  <= lpahp_pkg::AuthOpcodeRst;
      min_name_len_q <= lpahp_pkg::MinNameLenRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpahp_pkg::CfgServicePort: service_port_q <= cfg_data_i[15:0];
        lpahp_pkg::CfgAuthOpcode:  auth_opcode_q  <= cfg_data_i;
        lpahp_pkg::CfgMinNameLen:  min_name_len_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [15:0] in_port_q;
  logic        in_tcp_q;
  logic        in_last_q;
  logic        out_valid_q;
  logic        stall;
  logic        adv;

  assign stall           = out_valid_q && !m_axis_tready_i;
  assign adv             = in_valid_q && !stall;
  assign s_axis_tready_o = !in_valid_q || !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i[7:0];
      in_port_q <= s_axis_tdata_i[23:8];
      in_tcp_q  <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // packet state
  logic [15:0] pos_q, pos_d;
  logic [15:0] decl_q, decl_d;
  logic [31:0] opc_q, opc_d;
  logic [31:0] build_q, build_d;
  logic [15:0] port_q, port_d;
  logic        tcp_q, tcp_d;
  logic        run_q, run_d;
  logic [15:0] run_start_q, run_start_d;
  logic        scan_done_q, scan_done_d;
  logic        found_q, found_d;
  logic [5:0]  found_len_q, found_len_d;
  logic [15:0] found_off_q, found_off_d;

  logic [1:0]  opc_lane;
  logic [1:0]  build_lane;
  logic [15:0] run_len;
  logic [15:0] run_len_cap;
  logic        printable;
  logic        sat;
  logic        op_valid;
  lpahp_pkg::report_t rep_d, rep_q;

  always_comb begin
    opc_lane    = 2'(pos_q - 16'd2);
    build_lane  = 2'(pos_q - 16'd6);
    run_len     = pos_q - run_start_q;
    run_len_cap = (run_len < lpahp_pkg::NameMaxLength) ? run_len : lpahp_pkg::NameMaxLength;
    printable   = in_byte_q inside {[lpahp_pkg::PrintLow:lpahp_pkg::PrintHigh]};

    pos_d       = pos_q;
    decl_d      = decl_q;
    opc_d       = opc_q;
    build_d     = build_q;
    port_d      = port_q;
    tcp_d       = tcp_q;
    run_d       = run_q;
    run_start_d = run_start_q;
    scan_done_d = scan_done_q;
    found_d     = found_q;
    found_len_d = found_len_q;
    found_off_d = found_off_q;

    if (pos_q != lpahp_pkg::PosMax) begin
      if (pos_q == 16'd0) begin
        port_d = in_port_q;
        tcp_d  = in_tcp_q;
        decl_d = {in_byte_q, 8'd0};
      end else if (pos_q == 16'd1) begin
        decl_d = {decl_q[15:8], in_byte_q};
      end else if (pos_q <= 16'd5) begin
        opc_d[{opc_lane, 3'd0} +: 8] = in_byte_q;
      end else if (pos_q <= 16'd9) begin
        build_d[{build_lane, 3'd0} +: 8] = in_byte_q;
      end
      if (!scan_done_q && pos_q >= lpahp_pkg::ScanStart) begin
        if (printable) begin
          if (!run_q) begin
            run_start_d = pos_q;
            run_d       = 1'b1;
          end
        end else if (run_q && in_byte_q == 8'd0) begin
          if (run_len >= {10'd0, min_name_len_q}) begin
            found_d     = 1'b1;
            found_len_d = run_len_cap[5:0];
            found_off_d = run_start_q;
          end
          scan_done_d = 1'b1;
        end else begin
          run_d = 1'b0;
        end
      end
      pos_d = pos_q + 16'd1;
    end

    sat                = (pos_d == lpahp_pkg::PosMax);
    op_valid           = (pos_d >= lpahp_pkg::OpcodeLen);
    rep_d.length_match = tcp_d && (pos_d >= lpahp_pkg::MinMatchLen) && !sat
                         && (decl_d == pos_d - 16'd2) && (port_d == service_port_q);
    rep_d.opcode_valid = op_valid;
    rep_d.opcode       = op_valid ? opc_d : 32'd0;
    rep_d.is_auth      = op_valid && (opc_d == auth_opcode_q);
    rep_d.client_build = rep_d.is_auth ? build_d : 32'd0;
    rep_d.name_found   = rep_d.is_auth && found_d;
    rep_d.name_offset  = rep_d.name_found ? found_off_d : 16'd0;
    rep_d.name_length  = rep_d.name_found ? found_len_d : 6'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      decl_q      <= '0;
      opc_q       <= '0;
      build_q     <= '0;
      port_q      <= '0;
      tcp_q       <= 1'b0;
      run_q       <= 1'b0;
      run_start_q <= '0;
      scan_done_q <= 1'b0;
      found_q     <= 1'b0;
      found_len_q <= '0;
      found_off_q <= '0;
    end else if (adv) begin
      if (in_last_q) begin
        pos_q       <= '0;
        decl_q      <= '0;
        opc_q       <= '0;
        build_q     <= '0;
        port_q      <= '0;
        tcp_q       <= 1'b0;
        run_q       <= 1'b0;
        run_start_q <= '0;
        scan_done_q <= 1'b0;
        found_q     <= 1'b0;
        found_len_q <= '0;
        found_off_q <= '0;
      end else begin
        pos_q       <= pos_d;
        decl_q      <= decl_d;
        opc_q       <= opc_d;
        build_q     <= build_d;
        port_q      <= port_d;
        tcp_q       <= tcp_d;
        run_q       <= run_d;
        run_start_q <= run_start_d;
        scan_done_q <= scan_done_d;
        found_q     <= found_d;
        found_len_q <= found_len_d;
        found_off_q <= found_off_d;
      end
    end
  end

  // report register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      rep_q <= rep_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(lpahp_pkg::OutDataW - lpahp_pkg::ReportW)'(0), rep_q};

`ifndef SYNTHESIS
  a_last_gives_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_last_q |=> out_valid_q)
    else $error("last byte gave no report");

  a_last_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_last_q |=> pos_q == 16'd0)
    else $error("byte counter not cleared after packet");

  a_name_needs_auth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rep_q.name_found |-> rep_q.is_auth && rep_q.opcode_valid)
    else $error("name reported without auth opcode");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && stall |-> !s_axis_tready_o)
    else $error("input taken while pipeline stalled");

  a_scan_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> pos_q > lpahp_pkg::ScanStart)
    else $error("printable run open before scan start");
`endif

endmodule
